### hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg - shared constants and types for the 3x3 matrix inverse
// Port widths, register reset value, derived-width helpers, queue status.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int PORT_W = 32;
  localparam int THR_W = 48;
  localparam logic [THR_W-1:0] THR_RESET = 48'd281474977;
  localparam int EW_DEF = 32;
  localparam int FB_DEF = 16;
  localparam int NLANE = 9;

  // cofactor width; at full element width the difference wraps at 64 bits
  function automatic int cof_w(input int ew);
    return (2 * ew + 1 > 64) ? 64 : 2 * ew + 1;
  endfunction

  // determinant width: three EW x CW products summed
  function automatic int det_w(input int ew);
    return ew + cof_w(ew) + 2;
  endfunction

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

### hdl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front - cofactor and determinant pipeline
// Six stages: capture, 2x2 products, cofactors, split determinant products,
// determinant sum, magnitude and singular check.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int EW = mi3_pkg::EW_DEF,
  localparam int CW = mi3_pkg::cof_w(EW),
  localparam int DW = mi3_pkg::det_w(EW)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mi3_pkg::PORT_W-1:0]    in_elem [9],
  input  logic [mi3_pkg::THR_W-1:0]     thr,
  output logic                          fr_valid,
  input  logic                          fr_ready,
  output logic signed [CW-1:0]          fr_cof [9],
  output logic [DW-1:0]                 fr_dmag,
  output logic                          fr_dneg,
  output logic                          fr_sing
);
  import mi3_pkg::*;

  localparam int HB = CW / 2;
  localparam int LW = CW - HB;
  localparam int PW = 2 * EW;

  logic [5:0] v_r;
  logic       adv;

  logic signed [EW-1:0]    m_r [9];
  logic signed [PW-1:0]    pa_r [9];
  logic signed [PW-1:0]    pb_r [9];
  logic signed [EW-1:0]    m0_s2_r [3];
  logic signed [EW-1:0]    m0_s3_r [3];
  logic signed [CW-1:0]    cof_s3_r [9];
  logic signed [CW-1:0]    cof_s4_r [9];
  logic signed [CW-1:0]    cof_s5_r [9];
  logic signed [EW+HB:0]   plo_r [3];
  logic signed [EW+LW-1:0] phi_r [3];
  logic signed [DW-1:0]    det_r;
  logic signed [DW-1:0]    det_nxt;
  logic [DW-1:0]           dmag_nxt;

  // stages move together; a bubble is not squeezed out
  assign adv      = !v_r[5] || fr_ready;
  assign in_stall = !adv;
  assign fr_valid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_cof
      localparam int R = g / 3;
      localparam int C = g % 3;
      localparam int A = ((R + 1) % 3) * 3 + (C + 1) % 3;
      localparam int B = ((R + 2) % 3) * 3 + (C + 2) % 3;
      localparam int D = ((R + 1) % 3) * 3 + (C + 2) % 3;
      localparam int E = ((R + 2) % 3) * 3 + (C + 1) % 3;
      logic signed [PW:0] dfull;
      assign dfull = (PW+1)'(pa_r[g]) - (PW+1)'(pb_r[g]);
      always_ff @(posedge clk) begin
        if (adv) begin
          m_r[g]      <= $signed(in_elem[g][EW-1:0]);
          pa_r[g]     <= m_r[A] * m_r[B];
          pb_r[g]     <= m_r[D] * m_r[E];
          cof_s3_r[g] <= $signed(dfull[CW-1:0]);
          cof_s4_r[g] <= cof_s3_r[g];
          cof_s5_r[g] <= cof_s4_r[g];
          fr_cof[g]   <= cof_s5_r[g];
        end
      end
    end

    for (g = 0; g < 3; g++) begin : g_det
      logic signed [HB:0]    lo_s;
      logic signed [LW-1:0]  hi_s;
      assign lo_s = $signed({1'b0, cof_s3_r[g][HB-1:0]});
      assign hi_s = $signed(cof_s3_r[g][CW-1:HB]);
      always_ff @(posedge clk) begin
        if (adv) begin
          m0_s2_r[g] <= m_r[g];
          m0_s3_r[g] <= m0_s2_r[g];
          plo_r[g]   <= m0_s3_r[g] * lo_s;
          phi_r[g]   <= m0_s3_r[g] * hi_s;
        end
      end
    end
  endgenerate

  always_comb begin
    det_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      det_nxt = det_nxt + (DW'(phi_r[c]) <<< HB) + DW'(plo_r[c]);
    end
  end

  assign dmag_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r   <= det_nxt;
      fr_dneg <= det_r[DW-1];
      fr_dmag <= dmag_nxt;
      fr_sing <= (dmag_nxt == '0) || (dmag_nxt < DW'(thr));
    end
  end

endmodule

### hdl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue - short queue between front and back
// Register-based FIFO holding cofactors, determinant magnitude and flags.
// ----------------------------------------------------------------------------
module mi3_queue #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output mi3_pkg::q_stat_t  stat
);
  import mi3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign stat.not_empty = (cnt_r != '0);
  assign stat.not_full  = (cnt_r != (AW+1)'(DEPTH));
  assign do_push = push && stat.not_full;
  assign do_pop  = pop && stat.not_empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

endmodule

### hdl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back - nine bit-serial dividers and result register
// Each lane divides one shifted cofactor magnitude by the shared determinant
// magnitude, one quotient bit per cycle, then signs and saturates.
// ----------------------------------------------------------------------------
module mi3_back #(
  parameter int EW = mi3_pkg::EW_DEF,
  parameter int FB = mi3_pkg::FB_DEF,
  localparam int CW = mi3_pkg::cof_w(EW),
  localparam int DW = mi3_pkg::det_w(EW)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_take,
  input  logic signed [CW-1:0]        cof [9],
  input  logic [DW-1:0]               dmag,
  input  logic                        dneg,
  input  logic                        sing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mi3_pkg::PORT_W-1:0]  out_res [9],
  output logic                        out_singular,
  output logic                        out_saturated
);
  import mi3_pkg::*;

  localparam int NW = CW + 2 * FB;
  localparam int SW = DW + EW - 1;
  localparam int XW = max_i(NW, SW);
  localparam int XO = max_i(NW, DW + EW);
  localparam int CNTW = $clog2(EW + 1);

  logic            busy_r, sing_r, out_valid_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   dsh_r;
  logic            out_free, fin, step;
  logic [8:0]      sat_l;
  logic [EW-1:0]   res_l [9];

  assign out_free = !out_valid_r || !out_stall;
  assign fin      = busy_r && (cnt_r == '0) && out_free;
  assign q_take   = q_valid && (!busy_r || fin);
  assign step     = busy_r && (cnt_r != '0);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_take) begin
        busy_r <= 1'b1;
        cnt_r  <= sing ? '0 : CNTW'(EW);
      end else begin
        if (fin) busy_r <= 1'b0;
        if (step) cnt_r <= cnt_r - 1'b1;
      end
      if (fin) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      sing_r <= sing;
      dsh_r  <= SW'(dmag) << (EW - 1);
    end else if (step) begin
      dsh_r <= dsh_r >> 1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_lane
      // result [r][c] takes cofactor [c][r]
      localparam int SRC = (g % 3) * 3 + g / 3;
      logic [CW-1:0] cm;
      logic [NW-1:0] num;
      logic [NW-1:0] rem_r;
      logic [EW-1:0] q_r;
      logic          neg_r, ovf_r, ge;
      logic [XW-1:0] diff;

      assign cm   = cof[SRC][CW-1] ? CW'(-cof[SRC]) : CW'(cof[SRC]);
      assign num  = {cm, {(2*FB){1'b0}}};
      assign ge   = XW'(rem_r) >= XW'(dsh_r);
      assign diff = XW'(rem_r) - XW'(dsh_r);

      always_ff @(posedge clk) begin
        if (q_take) begin
          rem_r <= num;
          q_r   <= '0;
          neg_r <= cof[SRC][CW-1] ^ dneg;
          ovf_r <= XO'(num) >= (XO'(dmag) << EW);
        end else if (step) begin
          if (ge) rem_r <= diff[NW-1:0];
          q_r <= {q_r[EW-2:0], ge};
        end
      end

      // negative side may reach one step further than the positive side
      always_comb begin
        if (neg_r) begin
          sat_l[g] = ovf_r || (q_r[EW-1] && (q_r[EW-2:0] != '0));
          res_l[g] = sat_l[g] ? {1'b1, {(EW-1){1'b0}}} : -q_r;
        end else begin
          sat_l[g] = ovf_r || q_r[EW-1];
          res_l[g] = sat_l[g] ? {1'b0, {(EW-1){1'b1}}} : q_r;
        end
      end

      always_ff @(posedge clk) begin
        if (fin) begin
          out_res[g] <= sing_r ? '0 : PORT_W'($signed(res_l[g]));
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (fin) begin
      out_singular  <= sing_r;
      out_saturated <= !sing_r && (sat_l != '0);
    end
  end

endmodule

### hdl/matrix_inverse_3x3_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top - 3x3 fixed-point matrix inverse by the adjugate
// Takes a row-major 3x3 matrix of signed Q16.16 elements per transaction and
// returns its inverse: nine cofactors and the determinant are formed in
// a six-stage front pipeline, then nine bit-serial dividers (one quotient bit
// per cycle each, sharing the determinant) give the elements, truncated toward
// zero and saturated with out_saturated set. A determinant magnitude below
// cfg_wdata's threshold (Q.48 units) gives all zeros with out_singular set.
// The result passes the six front stages, the queue, the divider load, the
// quotient steps and the result register before out_valid rises; a singular
// matrix skips the quotient steps. The back end takes a new matrix only as
// it finishes the last one, and the front keeps accepting into a two-entry
// queue while the dividers work, until the queue fills.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top #(
  parameter int ELEMENT_WIDTH = mi3_pkg::EW_DEF,
  parameter int FRACTION_BITS = mi3_pkg::FB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mi3_pkg::THR_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r0c0,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r0c1,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r0c2,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r1c0,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r1c1,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r1c2,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r2c0,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r2c1,
  input  logic [mi3_pkg::PORT_W-1:0]  in_r2c2,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mi3_pkg::PORT_W-1:0]  out_r0c0,
  output logic [mi3_pkg::PORT_W-1:0]  out_r0c1,
  output logic [mi3_pkg::PORT_W-1:0]  out_r0c2,
  output logic [mi3_pkg::PORT_W-1:0]  out_r1c0,
  output logic [mi3_pkg::PORT_W-1:0]  out_r1c1,
  output logic [mi3_pkg::PORT_W-1:0]  out_r1c2,
  output logic [mi3_pkg::PORT_W-1:0]  out_r2c0,
  output logic [mi3_pkg::PORT_W-1:0]  out_r2c1,
  output logic [mi3_pkg::PORT_W-1:0]  out_r2c2,
  output logic                        out_singular,
  output logic                        out_saturated
);
  import mi3_pkg::*;

  localparam int CW = cof_w(ELEMENT_WIDTH);
  localparam int DW = det_w(ELEMENT_WIDTH);
  localparam int QW = 2 + DW + 9 * CW;

  logic [THR_W-1:0]   thr_r;
  logic [PORT_W-1:0]  in_elem [9];
  logic [PORT_W-1:0]  res [9];
  logic               fr_valid, fr_dneg, fr_sing;
  logic signed [CW-1:0] fr_cof [9];
  logic [DW-1:0]      fr_dmag;
  logic [QW-1:0]      q_wdata, q_rdata;
  q_stat_t            q_stat;
  logic               q_take;
  logic signed [CW-1:0] bk_cof [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign in_elem[0] = in_r0c0;
  assign in_elem[1] = in_r0c1;
  assign in_elem[2] = in_r0c2;
  assign in_elem[3] = in_r1c0;
  assign in_elem[4] = in_r1c1;
  assign in_elem[5] = in_r1c2;
  assign in_elem[6] = in_r2c0;
  assign in_elem[7] = in_r2c1;
  assign in_elem[8] = in_r2c2;

  mi3_front #(.EW(ELEMENT_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_elem  (in_elem),
    .thr      (thr_r),
    .fr_valid (fr_valid),
    .fr_ready (q_stat.not_full),
    .fr_cof   (fr_cof),
    .fr_dmag  (fr_dmag),
    .fr_dneg  (fr_dneg),
    .fr_sing  (fr_sing)
  );

  // entry layout: sing, dneg, dmag, cofactors 8..0
  assign q_wdata[QW-1]             = fr_sing;
  assign q_wdata[QW-2]             = fr_dneg;
  assign q_wdata[QW-3 -: DW]       = fr_dmag;

  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_pack
      assign q_wdata[g*CW +: CW] = fr_cof[g];
      assign bk_cof[g]           = $signed(q_rdata[g*CW +: CW]);
    end
  endgenerate

  mi3_queue #(.W(QW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .wdata (q_wdata),
    .pop   (q_take),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mi3_back #(.EW(ELEMENT_WIDTH), .FB(FRACTION_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_stat.not_empty),
    .q_take        (q_take),
    .cof           (bk_cof),
    .dmag          (q_rdata[QW-3 -: DW]),
    .dneg          (q_rdata[QW-2]),
    .sing          (q_rdata[QW-1]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (res),
    .out_singular  (out_singular),
    .out_saturated (out_saturated)
  );

  assign out_r0c0 = res[0];
  assign out_r0c1 = res[1];
  assign out_r0c2 = res[2];
  assign out_r1c0 = res[3];
  assign out_r1c1 = res[4];
  assign out_r1c2 = res[5];
  assign out_r2c0 = res[6];
  assign out_r2c1 = res[7];
  assign out_r2c2 = res[8];

endmodule
